[hdl/nnpo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnpo_pkg
// Shared types and constants of the nearest-neighbour point ordering block.
// ----------------------------------------------------------------------------
package nnpo_pkg;

  // capacity of the point store
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int COORD_W = 32;
  localparam int TAG_W   = 16;
  localparam int WORD_W  = 2 * COORD_W + TAG_W;
  localparam int ABS_W   = COORD_W + 1;
  localparam int DIST_W  = COORD_W + 2;

  // one stored point, x in the lowest bits
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

endpackage

[hdl/nnpo_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnpo_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nnpo_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/nearest_neighbor_point_order.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_point_order
// Loads a point set into a RAM, orders it greedily by Manhattan nearest
// neighbour with swaps in place, then streams the ordered run out.
// Loading keeps s_tready high. Ordering n points visits each position p from
// 1 to n-2 (only p = 1 for two points): it reads candidates p to n-1 through
// the single RAM read port, lets the pipeline drain and makes two swap writes.
// Emission reads each result once the output register is free, then loads it.
// Reset (synchronous, rst high) clears the sequencer, count and overflow flag;
// the RAM is not cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
module nearest_neighbor_point_order
  import nnpo_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [WORD_W-1:0] s_tdata,   // pad_x, pad_y, pad_tag
  input  logic              s_tlast,   // last_in
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [WORD_W-1:0] m_tdata,   // out_x, out_y, out_tag
  output logic              m_tlast,   // last_out
  output logic              m_tuser    // dropped
);

  state_t state, state_next;

  logic [CNT_W-1:0] count;
  logic             overflow;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] rd_idx;
  point_t           ref_pt;

  // ram ports
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  point_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_q;
  point_t           rd_pt;

  // distance pipeline
  logic              v1, v2;
  logic [IDX_W-1:0]  i1, i2;
  point_t            w2;
  logic [ABS_W-1:0]  abs_x, abs_y;
  logic [ABS_W-1:0]  dx, dy;
  logic [DIST_W-1:0] gap_sum;
  logic [DIST_W-1:0] best_d;
  logic [IDX_W-1:0]  best_idx;
  point_t            best_w;
  point_t            pos_w;

  logic s_acc;
  logic out_free;
  logic rd_last;
  logic pos_done;

  assign rd_pt    = point_t'(rd_q);
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign rd_last  = ({1'b0, rd_idx} + CNT_W'(1)) == count;
  // at most one candidate left after this position
  assign pos_done = ({1'b0, pos} + CNT_W'(2)) >= count;

  nnpo_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state and ram control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = count[IDX_W-1:0];
    wr_data    = point_t'(s_tdata);
    rd_en      = 1'b0;
    rd_addr    = rd_idx;
    unique case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        if (s_acc && (count < CNT_W'(MAX_POINTS))) begin
          wr_en = 1'b1;
        end
        if (s_acc && s_tlast) begin
          // a lone point needs no ordering
          state_next = (count == '0) ? ST_EMIT_RD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (rd_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = ST_SWAP_A;
        end
      end
      ST_SWAP_A: begin
        wr_en      = 1'b1;
        wr_addr    = best_idx;
        wr_data    = pos_w;
        state_next = ST_SWAP_B;
      end
      ST_SWAP_B: begin
        wr_en      = 1'b1;
        wr_addr    = pos;
        wr_data    = best_w;
        state_next = pos_done ? ST_EMIT_RD : ST_SCAN;
      end
      ST_EMIT_RD: begin
        if (out_free) begin
          rd_en      = 1'b1;
          state_next = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        state_next = rd_last ? ST_LOAD : ST_EMIT_RD;
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (state == ST_LOAD && s_acc) begin
      if (count < CNT_W'(MAX_POINTS)) begin
        count <= count + CNT_W'(1);
      end else begin
        overflow <= 1'b1;
      end
    end else if (state == ST_EMIT_LD && rd_last) begin
      count    <= '0;
      overflow <= 1'b0;
    end
  end

  // position and read index sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      rd_idx <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          pos    <= IDX_W'(1);
          rd_idx <= (count == '0) ? '0 : IDX_W'(1);
        end
        ST_SCAN: begin
          rd_idx <= rd_idx + IDX_W'(1);
        end
        ST_SWAP_B: begin
          pos    <= pos + IDX_W'(1);
          rd_idx <= pos_done ? '0 : pos + IDX_W'(1);
        end
        ST_EMIT_LD: begin
          rd_idx <= rd_idx + IDX_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // reference point: first loaded, then each placed point
  always_ff @(posedge clk) begin
    if (state == ST_LOAD && s_acc && count == '0) begin
      ref_pt <= point_t'(s_tdata);
    end else if (state == ST_SWAP_B) begin
      ref_pt <= best_w;
    end
  end

  // read valid tracking for the distance pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == ST_SCAN);
      v2 <= v1;
    end
  end

  // stage a: absolute coordinate differences
  assign dx = {rd_pt.x[COORD_W-1], rd_pt.x} - {ref_pt.x[COORD_W-1], ref_pt.x};
  assign dy = {rd_pt.y[COORD_W-1], rd_pt.y} - {ref_pt.y[COORD_W-1], ref_pt.y};

  always_ff @(posedge clk) begin
    i1 <= rd_idx;
    if (v1) begin
      abs_x <= dx[ABS_W-1] ? (~dx + ABS_W'(1)) : dx;
      abs_y <= dy[ABS_W-1] ? (~dy + ABS_W'(1)) : dy;
      i2    <= i1;
      w2    <= rd_pt;
    end
  end

  // stage b: sum and keep the nearest, earliest wins on ties
  assign gap_sum = {1'b0, abs_x} + {1'b0, abs_y};

  always_ff @(posedge clk) begin
    if (v2) begin
      if (i2 == pos) begin
        best_d   <= gap_sum;
        best_idx <= i2;
        best_w   <= w2;
        pos_w    <= w2;
      end else if (gap_sum < best_d) begin
        best_d   <= gap_sum;
        best_idx <= i2;
        best_w   <= w2;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT_LD) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT_LD) begin
      m_tdata <= rd_q;
      m_tlast <= rd_last;
      m_tuser <= overflow;
    end
  end

endmodule

[bench/nearest_neighbor_point_order_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_point_order_test
// Streams pad point sets into the ordering block and checks each emitted
// run against a greedy Manhattan nearest-neighbour ordering computed here.
// Directed sets cover coordinate extremes, ties, duplicates and a single
// point. Random small sets follow, plus one set over capacity,
// under changing sender idle and receiver stall rates.
// ----------------------------------------------------------------------------
module nearest_neighbor_point_order_test;
  import nnpo_pkg::*;

  localparam int SRC_IDLE [4]  = '{0, 77, 0, 22};
  localparam int SINK_STALL [4] = '{0, 0, 77, 22};
  localparam int PHASE_ITEMS   = 20;

  // one expected item of an emitted run
  typedef struct {
    point_t pt;
    logic   last_out;
    logic   dropped;
  } ordered_point_t;

  // greedy ordering of the collected set and the queue of expected items
  class point_order_board;
    point_t         held_points[$];
    logic           overflow_seen;
    ordered_point_t expected_order[$];
    int             errors;

    function new();
      overflow_seen = 1'b0;
      errors        = 0;
    endfunction

    function longint manhattan_gap(point_t a, point_t b);
      longint dx;
      longint dy;
      dx = longint'($signed(a.x)) - longint'($signed(b.x));
      dy = longint'($signed(a.y)) - longint'($signed(b.y));
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return dx + dy;
    endfunction

    // note one accepted point; on the closing point order the set
    function void note_point(point_t pt, logic last_in);
      int             best;
      longint         best_gap;
      longint         gap;
      point_t         spare;
      ordered_point_t item;
      if (held_points.size() < MAX_POINTS) held_points.push_back(pt);
      else overflow_seen = 1'b1;
      if (!last_in) return;
      for (int p = 1; p < held_points.size(); p++) begin
        best     = p;
        best_gap = manhattan_gap(held_points[p], held_points[p-1]);
        for (int k = p + 1; k < held_points.size(); k++) begin
          gap = manhattan_gap(held_points[k], held_points[p-1]);
          if (gap < best_gap) begin
            best_gap = gap;
            best     = k;
          end
        end
        spare             = held_points[p];
        held_points[p]    = held_points[best];
        held_points[best] = spare;
      end
      foreach (held_points[k]) begin
        item.pt       = held_points[k];
        item.last_out = (k == held_points.size() - 1);
        item.dropped  = overflow_seen;
        expected_order.push_back(item);
      end
      held_points.delete();
      overflow_seen = 1'b0;
    endfunction

    // compare one emitted item with the oldest expectation
    function void check_result(point_t pt, logic last_out, logic dropped);
      ordered_point_t want;
      if (expected_order.size() == 0) begin
        $display("%0t: unexpected item x=%h y=%h tag=%h", $time, pt.x, pt.y, pt.tag);
        errors++;
        return;
      end
      want = expected_order.pop_front();
      if (pt.x !== want.pt.x) begin
        $display("%0t: out_x expected %h actual %h", $time, want.pt.x, pt.x);
        errors++;
      end
      if (pt.y !== want.pt.y) begin
        $display("%0t: out_y expected %h actual %h", $time, want.pt.y, pt.y);
        errors++;
      end
      if (pt.tag !== want.pt.tag) begin
        $display("%0t: out_tag expected %h actual %h", $time, want.pt.tag, pt.tag);
        errors++;
      end
      if (last_out !== want.last_out) begin
        $display("%0t: last_out expected %b actual %b", $time, want.last_out, last_out);
        errors++;
      end
      if (dropped !== want.dropped) begin
        $display("%0t: dropped expected %b actual %b", $time, want.dropped, dropped);
        errors++;
      end
    endfunction

    function int pending();
      return expected_order.size();
    endfunction
  endclass

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [WORD_W-1:0] s_tdata  = '0;   // pad_x, pad_y, pad_tag
  logic              s_tlast  = 1'b0; // last_in
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [WORD_W-1:0] m_tdata;         // out_x, out_y, out_tag
  logic              m_tlast;         // last_out
  logic              m_tuser;         // dropped

  point_order_board board;
  int               src_idle   = 0;
  int               sink_stall = 0;
  int               items_sent = 0;

  nearest_neighbor_point_order DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // receiver: check accepted items, stall at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(point_t'(m_tdata), m_tlast, m_tuser);
    m_tready <= ($urandom_range(0, 99) >= sink_stall);
  end

  // offer one point, holding valid until it is taken
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [TAG_W-1:0] tag, input logic last_in);
    point_t pt;
    pt.x   = x;
    pt.y   = y;
    pt.tag = tag;
    if ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pt;
    s_tlast  <= last_in;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_point(pt, last_in);
    items_sent++;
  endtask

  // extremes, small values that make ties likely, or anything
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3, 4: return 32'($urandom_range(0, 6)) - 32'd3;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_random_set(input int count);
    for (int i = 0; i < count; i++) send_point(pick_coord(), pick_coord(), pick_tag(), i == count - 1);
  endtask

  // run time limit
  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int set_size;
    int phase_start;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // a lone point
    send_point(32'h7fff_ffff, 32'h8000_0000, 16'hffff, 1'b1);
    // corners of the coordinate range, widest distances
    send_point(32'h8000_0000, 32'h8000_0000, 16'd0, 1'b0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 16'd1, 1'b0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 16'd2, 1'b0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 16'd3, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 16'd4, 1'b1);
    // equal distances around the origin, earliest must win
    send_point(32'd0, 32'd0, 16'd10, 1'b0);
    send_point(32'd1, 32'd0, 16'd11, 1'b0);
    send_point(32'd0, 32'd1, 16'd12, 1'b0);
    send_point(32'hffff_ffff, 32'd0, 16'd13, 1'b0);
    send_point(32'd0, 32'hffff_ffff, 16'd14, 1'b0);
    send_point(32'd1, 32'd0, 16'd15, 1'b1);
    // duplicates
    send_point(32'd5, 32'd5, 16'd20, 1'b0);
    send_point(32'd5, 32'd5, 16'd21, 1'b0);
    send_point(32'd5, 32'd5, 16'd22, 1'b1);
    // two points, tag extremes
    send_point(32'hffff_ffff, 32'hffff_ffff, 16'h0000, 1'b0);
    send_point(32'd0, 32'd0, 16'hffff, 1'b1);

    // random sets under each idling mix
    for (int phase = 0; phase < 4; phase++) begin
      src_idle    = SRC_IDLE[phase];
      sink_stall  = SINK_STALL[phase];
      // one set past capacity, its closing point dropped too
      if (phase == 2) send_random_set(MAX_POINTS + 1);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        set_size = $urandom_range(1, 8);
        send_random_set(set_size);
      end
    end
    s_tvalid <= 1'b0;

    // drain
    while (board.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
